[hw/rtl/wwb_pkg.sv]
// shared types, constants and the kernel weight function of the window blur
// no dependencies
package wwb_pkg;

  localparam int MaxWidth    = 1024;
  localparam int Radius      = 3;
  localparam int CenterExtra = 10;
  localparam int Span        = 2 * Radius + 1;
  localparam int StoreSize   = 2 * Radius * MaxWidth + 2 * Radius + 2;
  localparam int AddrW       = $clog2(StoreSize);
  localparam int WidthW      = 11;
  localparam int HeightW     = 12;
  localparam int ColW        = 10;
  localparam int RowW        = 12;
  localparam int PendW       = 13;
  localparam int SumW        = 16;
  localparam int DivW        = 8;
  localparam int WtW         = 5;
  localparam int CntW        = $clog2(Span);
  localparam int OffW        = $clog2(Radius + 1);
  localparam int QDepth      = 4;
  localparam int QPtrW       = $clog2(QDepth);

  localparam logic CFG_FRAME_WIDTH  = 1'b0;
  localparam logic CFG_FRAME_HEIGHT = 1'b1;

  typedef struct packed {
    logic       flush;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } item_t;

  typedef struct packed {
    logic                      start;
    logic [DivW-1:0]           divisor;
    logic [2:0][SumW-1:0]      dividend;
  } div_req_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_NEED,
    ST_DECIDE,
    ST_ACC,
    ST_DIV,
    ST_OUT
  } state_t;

  function automatic logic [WtW-1:0] kernel_weight(logic [CntW-1:0] dxi,
                                                   logic [CntW-1:0] dyi);
    logic [WtW-1:0] adx;
    logic [WtW-1:0] ady;
    logic [WtW-1:0] wt;
    adx = (dxi >= CntW'(Radius)) ? WtW'(dxi - CntW'(Radius)) : WtW'(CntW'(Radius) - dxi);
    ady = (dyi >= CntW'(Radius)) ? WtW'(dyi - CntW'(Radius)) : WtW'(CntW'(Radius) - dyi);
    wt  = WtW'(2 * Radius) - adx - ady;
    if (adx == '0 && ady == '0) begin
      wt = wt + WtW'(CenterExtra);
    end
    return wt;
  endfunction

endpackage

[hw/rtl/wwb_front.sv]
// front queue: accepts input transactions and tags pixels versus flush ticks
// uses wwb_pkg
module wwb_front (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_push,
  output logic               in_full,
  input  logic               in_action,
  input  logic [7:0]         in_red_in,
  input  logic [7:0]         in_green_in,
  input  logic [7:0]         in_blue_in,
  output logic               item_valid,
  output wwb_pkg::item_t     item,
  input  logic               item_pop
);

  wwb_pkg::item_t                 q_r [wwb_pkg::QDepth];
  logic [wwb_pkg::QPtrW-1:0]      wr_ptr_r, wr_ptr_nxt;
  logic [wwb_pkg::QPtrW-1:0]      rd_ptr_r, rd_ptr_nxt;
  logic [wwb_pkg::QPtrW:0]        cnt_r, cnt_nxt;
  logic                           do_push, do_pop;

  assign in_full    = (cnt_r == (wwb_pkg::QPtrW+1)'(wwb_pkg::QDepth));
  assign item_valid = (cnt_r != '0);
  assign item       = q_r[rd_ptr_r];
  assign do_push    = in_push && !in_full;
  assign do_pop     = item_pop && item_valid;

  always_comb begin
    wr_ptr_nxt = do_push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = do_pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    cnt_nxt    = cnt_r + (wwb_pkg::QPtrW+1)'(do_push) - (wwb_pkg::QPtrW+1)'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      q_r[wr_ptr_r] <= '{flush: in_action, red: in_red_in, green: in_green_in,
                         blue: in_blue_in};
    end
  end

endmodule

[hw/rtl/wwb_div.sv]
// three-lane restoring divider, one quotient bit per cycle, shared divisor
// uses wwb_pkg
module wwb_div (
  input  logic                                    clk,
  input  logic                                    rst_n,
  input  wwb_pkg::div_req_t                       req,
  output logic                                    busy,
  output logic [2:0][7:0]                         quotient
);

  localparam int CW = $clog2(wwb_pkg::SumW + 1);

  logic [2:0][wwb_pkg::SumW-1:0] quo_r, quo_nxt;
  logic [2:0][wwb_pkg::DivW-1:0] rem_r, rem_nxt;
  logic [wwb_pkg::DivW-1:0]      dvs_r;
  logic [CW-1:0]                 cnt_r, cnt_nxt;
  logic                          busy_r, busy_nxt;
  logic [wwb_pkg::DivW:0]        trial;

  assign busy = busy_r;

  always_comb begin
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    trial    = '0;
    if (req.start) begin
      quo_nxt  = req.dividend;
      rem_nxt  = '0;
      cnt_nxt  = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      for (int ch = 0; ch < 3; ch++) begin
        trial = {rem_r[ch], quo_r[ch][wwb_pkg::SumW-1]};
        if (trial >= {1'b0, dvs_r}) begin
          trial       = trial - {1'b0, dvs_r};
          quo_nxt[ch] = {quo_r[ch][wwb_pkg::SumW-2:0], 1'b1};
        end else begin
          quo_nxt[ch] = {quo_r[ch][wwb_pkg::SumW-2:0], 1'b0};
        end
        rem_nxt[ch] = trial[wwb_pkg::DivW-1:0];
      end
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == CW'(wwb_pkg::SumW - 1)) begin
        busy_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    if (req.start) begin
      dvs_r <= req.divisor;
    end
  end

  always_comb begin
    for (int ch = 0; ch < 3; ch++) begin
      quotient[ch] = quo_r[ch][7:0];
    end
  end

endmodule

[hw/rtl/wwb_back.sv]
// back end: row store, window sequencer, accumulators and result register
// uses wwb_pkg; drives the wwb_div divider through a request struct
module wwb_back (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic                          cfg_index,
  input  logic [11:0]                   cfg_data,
  input  logic                          item_valid,
  input  wwb_pkg::item_t                item,
  output logic                          item_pop,
  output wwb_pkg::div_req_t             div_req,
  input  logic                          div_busy,
  input  logic [2:0][7:0]               div_quo,
  output logic                          out_empty,
  input  logic                          out_pop,
  output logic [7:0]                    out_red_out,
  output logic [7:0]                    out_green_out,
  output logic [7:0]                    out_blue_out,
  output logic                          out_end_of_frame
);

  localparam int AW = wwb_pkg::AddrW;

  function automatic logic [AW-1:0] wrap(logic [AW:0] v);
    logic [AW:0] r;
    r = (v >= (AW+1)'(wwb_pkg::StoreSize)) ? v - (AW+1)'(wwb_pkg::StoreSize) : v;
    return r[AW-1:0];
  endfunction

  logic [23:0] mem [wwb_pkg::StoreSize];
  logic [23:0] rd_data_r;
  logic        mem_we;
  logic [AW-1:0] rd_addr;

  logic [wwb_pkg::WidthW-1:0]  width_r;
  logic [wwb_pkg::HeightW-1:0] height_r;
  logic [wwb_pkg::WidthW-1:0]  eff_w;
  logic [wwb_pkg::HeightW-1:0] eff_h;

  wwb_pkg::state_t state_r, state_nxt;
  logic [wwb_pkg::ColW-1:0]  in_col_r, in_col_nxt, out_col_r, out_col_nxt;
  logic [wwb_pkg::RowW-1:0]  in_row_r, in_row_nxt, out_row_r, out_row_nxt;
  logic [wwb_pkg::PendW-1:0] pend_r, pend_nxt, need_r, need_nxt;
  logic [AW-1:0]             in_slot_r, in_slot_nxt, out_slot_r, out_slot_nxt;
  logic [AW-1:0]             rowbase_r, rowbase_nxt;
  logic [wwb_pkg::CntW-1:0]  dxi_r, dxi_nxt, dyi_r, dyi_nxt;
  logic                      a_run_r, a_run_nxt, b_valid_r, b_valid_nxt;
  logic [wwb_pkg::WtW-1:0]   b_wt_r, b_wt_nxt;
  logic [2:0][wwb_pkg::SumW-1:0] sum_r, sum_nxt;
  logic [wwb_pkg::DivW-1:0]  dsum_r, dsum_nxt;
  logic                      out_valid_r, out_valid_nxt;
  logic [7:0]                ored_r, ogreen_r, oblue_r;
  logic                      oeof_r;
  logic                      out_load;

  logic [wwb_pkg::RowW:0]    oy_ext, last_row;
  logic [wwb_pkg::ColW+1:0]  ox_ext, last_col;
  logic [wwb_pkg::OffW-1:0]  rows_off, cols_off;
  logic [wwb_pkg::RowW:0]    yy;
  logic [wwb_pkg::ColW+1:0]  xx;
  logic                      tap_ok;
  logic [AW:0]               three_w;
  logic                      pop_now;

  always_comb begin
    if (width_r == '0) begin
      eff_w = wwb_pkg::WidthW'(1);
    end else if (width_r > wwb_pkg::WidthW'(wwb_pkg::MaxWidth)) begin
      eff_w = wwb_pkg::WidthW'(wwb_pkg::MaxWidth);
    end else begin
      eff_w = width_r;
    end
    eff_h = (height_r == '0) ? wwb_pkg::HeightW'(1) : height_r;
  end

  // window tap bounds and read address
  always_comb begin
    yy      = {1'b0, out_row_r} + (wwb_pkg::RowW+1)'(dyi_r);
    xx      = {2'b0, out_col_r} + (wwb_pkg::ColW+2)'(dxi_r);
    tap_ok  = (yy >= (wwb_pkg::RowW+1)'(wwb_pkg::Radius))
           && (yy < {1'b0, eff_h} + (wwb_pkg::RowW+1)'(wwb_pkg::Radius))
           && (xx >= (wwb_pkg::ColW+2)'(wwb_pkg::Radius))
           && (xx < {1'b0, eff_w} + (wwb_pkg::ColW+2)'(wwb_pkg::Radius));
    rd_addr = wrap({1'b0, rowbase_r} + (AW+1)'(dxi_r));
    three_w = (AW+1)'(eff_w) + (AW+1)'({eff_w, 1'b0});
  end

  // last row and column of the window that must be in before a result
  always_comb begin
    oy_ext   = {1'b0, out_row_r} + (wwb_pkg::RowW+1)'(wwb_pkg::Radius);
    last_row = (oy_ext < {1'b0, eff_h}) ? oy_ext : {1'b0, eff_h} - 1'b1;
    ox_ext   = {2'b0, out_col_r} + (wwb_pkg::ColW+2)'(wwb_pkg::Radius);
    last_col = (ox_ext < {1'b0, eff_w}) ? ox_ext : {1'b0, eff_w} - 1'b1;
    rows_off = wwb_pkg::OffW'(last_row - {1'b0, out_row_r});
    cols_off = wwb_pkg::OffW'(last_col - {2'b0, out_col_r});
  end

  assign pop_now  = out_pop && out_valid_r;
  assign out_load = (state_r == wwb_pkg::ST_OUT) && (!out_valid_r || pop_now);

  always_comb begin
    state_nxt    = state_r;
    in_col_nxt   = in_col_r;
    in_row_nxt   = in_row_r;
    out_col_nxt  = out_col_r;
    out_row_nxt  = out_row_r;
    pend_nxt     = pend_r;
    need_nxt     = need_r;
    in_slot_nxt  = in_slot_r;
    out_slot_nxt = out_slot_r;
    rowbase_nxt  = rowbase_r;
    dxi_nxt      = dxi_r;
    dyi_nxt      = dyi_r;
    a_run_nxt    = a_run_r;
    b_valid_nxt  = 1'b0;
    b_wt_nxt     = '0;
    sum_nxt      = sum_r;
    dsum_nxt     = dsum_r;
    item_pop     = 1'b0;
    mem_we       = 1'b0;
    div_req.start    = 1'b0;
    div_req.divisor  = (dsum_r == '0) ? wwb_pkg::DivW'(1) : dsum_r;
    div_req.dividend = sum_r;
    case (state_r)
      wwb_pkg::ST_IDLE: begin
        if (item_valid) begin
          item_pop  = 1'b1;
          state_nxt = wwb_pkg::ST_NEED;
          if (!item.flush) begin
            mem_we      = 1'b1;
            in_slot_nxt = wrap({1'b0, in_slot_r} + 1'b1);
            pend_nxt    = pend_r + 1'b1;
            if ({1'b0, in_col_r} + 1'b1 >= eff_w) begin
              in_col_nxt = '0;
              in_row_nxt = ((in_row_r + 1'b1) >= eff_h) ? '0 : in_row_r + 1'b1;
            end else begin
              in_col_nxt = in_col_r + 1'b1;
            end
          end
        end
      end
      wwb_pkg::ST_NEED: begin
        need_nxt  = wwb_pkg::PendW'(rows_off) * wwb_pkg::PendW'(eff_w)
                  + wwb_pkg::PendW'(cols_off);
        state_nxt = wwb_pkg::ST_DECIDE;
      end
      wwb_pkg::ST_DECIDE: begin
        if (pend_r > need_r) begin
          dxi_nxt     = '0;
          dyi_nxt     = '0;
          a_run_nxt   = 1'b1;
          sum_nxt     = '0;
          dsum_nxt    = '0;
          rowbase_nxt = wrap({1'b0, out_slot_r} + (AW+1)'(wwb_pkg::StoreSize)
                             - three_w - (AW+1)'(wwb_pkg::Radius));
          state_nxt   = wwb_pkg::ST_ACC;
        end else begin
          state_nxt = wwb_pkg::ST_IDLE;
        end
      end
      wwb_pkg::ST_ACC: begin
        // tap issue: one store read per cycle, weight follows the data
        // taps outside the frame are not accumulated at all
        if (a_run_r) begin
          b_valid_nxt = tap_ok;
          b_wt_nxt    = tap_ok ? wwb_pkg::kernel_weight(dxi_r, dyi_r) : '0;
          if (dxi_r == wwb_pkg::CntW'(wwb_pkg::Span - 1)) begin
            dxi_nxt     = '0;
            rowbase_nxt = wrap({1'b0, rowbase_r} + (AW+1)'(eff_w));
            if (dyi_r == wwb_pkg::CntW'(wwb_pkg::Span - 1)) begin
              a_run_nxt = 1'b0;
            end else begin
              dyi_nxt = dyi_r + 1'b1;
            end
          end else begin
            dxi_nxt = dxi_r + 1'b1;
          end
        end
        // accumulate
        if (b_valid_r) begin
          sum_nxt[0] = sum_r[0]
                     + wwb_pkg::SumW'(rd_data_r[23:16]) * wwb_pkg::SumW'(b_wt_r);
          sum_nxt[1] = sum_r[1]
                     + wwb_pkg::SumW'(rd_data_r[15:8]) * wwb_pkg::SumW'(b_wt_r);
          sum_nxt[2] = sum_r[2]
                     + wwb_pkg::SumW'(rd_data_r[7:0]) * wwb_pkg::SumW'(b_wt_r);
          dsum_nxt   = dsum_r + wwb_pkg::DivW'(b_wt_r);
        end
        if (!a_run_r && !b_valid_r) begin
          div_req.start = 1'b1;
          state_nxt     = wwb_pkg::ST_DIV;
        end
      end
      wwb_pkg::ST_DIV: begin
        if (!div_busy) begin
          state_nxt = wwb_pkg::ST_OUT;
        end
      end
      wwb_pkg::ST_OUT: begin
        if (out_load) begin
          pend_nxt     = pend_r - 1'b1;
          out_slot_nxt = wrap({1'b0, out_slot_r} + 1'b1);
          if ({1'b0, out_col_r} + 1'b1 >= eff_w) begin
            out_col_nxt = '0;
            out_row_nxt = ((out_row_r + 1'b1) >= eff_h) ? '0 : out_row_r + 1'b1;
          end else begin
            out_col_nxt = out_col_r + 1'b1;
          end
          state_nxt = wwb_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = wwb_pkg::ST_IDLE;
      end
    endcase
  end

  assign out_valid_nxt = (out_valid_r && !pop_now) || out_load;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= wwb_pkg::ST_IDLE;
      width_r     <= wwb_pkg::WidthW'(1024);
      height_r    <= wwb_pkg::HeightW'(768);
      in_col_r    <= '0;
      in_row_r    <= '0;
      out_col_r   <= '0;
      out_row_r   <= '0;
      pend_r      <= '0;
      in_slot_r   <= '0;
      out_slot_r  <= '0;
      a_run_r     <= 1'b0;
      b_valid_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      a_run_r     <= a_run_nxt;
      b_valid_r   <= b_valid_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        // a register write restarts the stream
        if (cfg_index == wwb_pkg::CFG_FRAME_WIDTH) begin
          width_r <= cfg_data[wwb_pkg::WidthW-1:0];
        end else begin
          height_r <= cfg_data[wwb_pkg::HeightW-1:0];
        end
        in_col_r   <= '0;
        in_row_r   <= '0;
        out_col_r  <= '0;
        out_row_r  <= '0;
        pend_r     <= '0;
        in_slot_r  <= '0;
        out_slot_r <= '0;
      end else begin
        in_col_r   <= in_col_nxt;
        in_row_r   <= in_row_nxt;
        out_col_r  <= out_col_nxt;
        out_row_r  <= out_row_nxt;
        pend_r     <= pend_nxt;
        in_slot_r  <= in_slot_nxt;
        out_slot_r <= out_slot_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    need_r    <= need_nxt;
    rowbase_r <= rowbase_nxt;
    dxi_r     <= dxi_nxt;
    dyi_r     <= dyi_nxt;
    b_wt_r    <= b_wt_nxt;
    sum_r     <= sum_nxt;
    dsum_r    <= dsum_nxt;
    if (out_load) begin
      ored_r   <= div_quo[0];
      ogreen_r <= div_quo[1];
      oblue_r  <= div_quo[2];
      oeof_r   <= ({1'b0, out_col_r} == eff_w - 1'b1) && (out_row_r == eff_h - 1'b1);
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[in_slot_r] <= {item.red, item.green, item.blue};
    end
    rd_data_r <= mem[rd_addr];
  end

  assign out_empty        = !out_valid_r;
  assign out_red_out      = ored_r;
  assign out_green_out    = ogreen_r;
  assign out_blue_out     = oblue_r;
  assign out_end_of_frame = oeof_r;

endmodule

[hw/rtl/weighted_window_blur.sv]
// top level of the 7x7 diamond weighted blur over an rgb888 raster stream
// uses wwb_pkg, wwb_front, wwb_back and wwb_div
//
// usage
//   input side is a queue: write a transaction with in_push while in_full is low;
//   in_action low carries a pixel, high is a flush tick that lets pending
//   results drain at the end of a frame
//   result side is a queue: while out_empty is low the oldest result sits on
//   the out_ ports; out_pop takes it
//   cfg_we writes frame_width (index 0) or frame_height (index 1) and restarts
//   the stream; write only while the block is idle
// timing
//   a four-entry input queue takes transactions while the back end works
//   an item that gives no result takes about 3 cycles in the back end
//   an item that gives a result takes about 72 cycles: 49 store reads of the
//   window (one store read port), 16 divider steps, plus sequencing
//   the first result of a frame needs 3 rows plus 4 pixels of input
// reset and stalls
//   reset empties both queues and zeroes positions; the row store is not
//   cleared, no result ever reads an entry before it is written
//   a result waiting for out_pop holds the back end, the input queue then
//   fills and in_full rises
module weighted_window_blur (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [11:0] cfg_data,
  input  logic        in_push,
  output logic        in_full,
  input  logic        in_action,
  input  logic [7:0]  in_red_in,
  input  logic [7:0]  in_green_in,
  input  logic [7:0]  in_blue_in,
  output logic        out_empty,
  input  logic        out_pop,
  output logic [7:0]  out_red_out,
  output logic [7:0]  out_green_out,
  output logic [7:0]  out_blue_out,
  output logic        out_end_of_frame
);

  // queue between front and back
  wwb_pkg::item_t    item;
  logic              item_valid;
  logic              item_pop;

  // divider hookup
  wwb_pkg::div_req_t div_req;
  logic              div_busy;
  logic [2:0][7:0]   div_quo;

  wwb_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_push    (in_push),
    .in_full    (in_full),
    .in_action  (in_action),
    .in_red_in  (in_red_in),
    .in_green_in(in_green_in),
    .in_blue_in (in_blue_in),
    .item_valid (item_valid),
    .item       (item),
    .item_pop   (item_pop)
  );

  wwb_div u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .req     (div_req),
    .busy    (div_busy),
    .quotient(div_quo)
  );

  // window sequencing, row store and result register
  wwb_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .item_valid      (item_valid),
    .item            (item),
    .item_pop        (item_pop),
    .div_req         (div_req),
    .div_busy        (div_busy),
    .div_quo         (div_quo),
    .out_empty       (out_empty),
    .out_pop         (out_pop),
    .out_red_out     (out_red_out),
    .out_green_out   (out_green_out),
    .out_blue_out    (out_blue_out),
    .out_end_of_frame(out_end_of_frame)
  );

endmodule
